// ===== src/brf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and defaults for the byte ring FIFO with frame pop.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DEPTH_DEF           = 256;
    localparam int MAX_FRAME_BYTES_DEF = 64;

    localparam int FILL_W = 16;

    localparam logic [7:0] HEADER_BYTE = 8'h7E;
    localparam logic [5:0] MAX_LEN_RST = 6'd58;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_SHORT = 3'd3;
    localparam logic [2:0] ST_LONG  = 3'd4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] in_byte;
    } brf_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last_byte;
        logic [7:0] fill_level;
    } brf_rsp_t;

    typedef struct packed {
        logic rd_inc;
        logic wr_inc;
        logic clear;
        logic drop_all;
    } brf_ptr_cmd_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [FILL_W-1:0] fill;
    } brf_ptr_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LO,
        S_HI,
        S_HDR,
        S_BODY
    } brf_state_t;

endpackage

// ===== src/brf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ram
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brf_ram import brf_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/brf_ring_ptrs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ring_ptrs
// Read and write pointers of the ring, with fill level, empty and full.
// ----------------------------------------------------------------------------
module brf_ring_ptrs import brf_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  brf_ptr_cmd_t             cmd,
    output logic [$clog2(DEPTH)-1:0] rd_ptr,
    output logic [$clog2(DEPTH)-1:0] wr_ptr,
    output brf_ptr_stat_t            stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W + 1)'(DEPTH);

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_inc_val, wr_inc_val;
    logic [PTR_W:0]   diff;

    assign rd_inc_val = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_inc_val = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (cmd.clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
        end
        else
        begin
            if (cmd.drop_all)
            begin
                rd_ptr_next = wr_ptr_reg;
            end
            else if (cmd.rd_inc)
            begin
                rd_ptr_next = rd_inc_val;
            end
            if (cmd.wr_inc)
            begin
                wr_ptr_next = wr_inc_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_comb
    begin
        diff = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
        if (wr_ptr_reg < rd_ptr_reg)
        begin
            diff = diff + DEPTH_W;
        end
    end

    assign stat.fill  = FILL_W'(diff[PTR_W-1:0]);
    assign stat.empty = (rd_ptr_reg == wr_ptr_reg);
    assign stat.full  = (wr_inc_val == rd_ptr_reg);
    assign rd_ptr     = rd_ptr_reg;
    assign wr_ptr     = wr_ptr_reg;

endmodule

// ===== src/brf_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_out_reg
// Result holding register on the valid/stall output channel.
// ----------------------------------------------------------------------------
module brf_out_reg import brf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  brf_rsp_t load_data,
    input  logic     rsp_stall,
    output logic     slot_free,
    output logic     rsp_valid,
    output brf_rsp_t rsp
);

    logic     valid_reg;
    brf_rsp_t data_reg;

    // slot can take a beat when empty or when the held beat leaves now
    assign slot_free = !valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && load)
        begin
            data_reg <= load_data;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

// ===== src/byte_ring_fifo_with_frame_pop.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_frame_pop
// Ring byte FIFO with push, pop, clear and framed pop over a byte store.
// ----------------------------------------------------------------------------
// Push and clear: result beat in the cycle after accept.
// Pop: the byte goes through the store's read register and is loaded in S_POP.
// Frame pop: bytes up to and including the header are scanned, the length bytes
// are taken, then one beat per cycle (header, length, body) unless stalled.
// One item at a time. Reset clears both pointers and sets max_body_len to 58;
// store contents are undefined until written.
module byte_ring_fifo_with_frame_pop import brf_pkg::*; #(
    parameter int DEPTH           = DEPTH_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  brf_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output brf_rsp_t rsp,
    input  logic     cfg_we,
    input  logic [5:0] cfg_wdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [5:0] LEN_CAP = 6'(MAX_FRAME_BYTES - 6);

    brf_state_t state_reg, state_next;

    logic [5:0]       max_len_reg;
    logic [7:0]       lo_reg;
    logic [1:0]       hdr_idx_reg;
    logic [CNT_W-1:0] rem_reg;

    brf_ptr_cmd_t     ptr_cmd;
    brf_ptr_stat_t    ptr_stat;
    logic [PTR_W-1:0] rd_ptr, wr_ptr;
    logic [7:0]       rd_data;
    logic             mem_we, mem_re;

    logic     out_load, slot_free;
    brf_rsp_t out_item;

    logic        accept;
    logic        hdr_match;
    logic        few_left;
    logic [15:0] len_w;
    logic [5:0]  limit;
    logic        too_long, too_short;
    logic [FILL_W-1:0] fill_hdr;

    assign req_stall = (state_reg != S_IDLE) || !slot_free;
    assign accept    = req_valid && !req_stall;
    assign hdr_match = (rd_data == HEADER_BYTE);
    assign few_left  = (ptr_stat.fill < FILL_W'(2));
    assign len_w     = {rd_data, lo_reg};
    assign limit     = (max_len_reg > LEN_CAP) ? LEN_CAP : max_len_reg;
    assign too_long  = (len_w > {10'd0, limit});
    assign too_short = ({1'b0, ptr_stat.fill} < ({1'b0, len_w} + 17'd3));
    // header beat reports fill before both length bytes were taken
    assign fill_hdr  = ptr_stat.fill + FILL_W'(2'd2 - hdr_idx_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == OP_POP && !ptr_stat.empty)
                    begin
                        state_next = S_POP;
                    end
                    else if (req.opcode == OP_FRAME)
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            S_SCAN_RD:
            begin
                state_next = ptr_stat.empty ? S_IDLE : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (hdr_match)
                begin
                    state_next = few_left ? S_IDLE : S_LO;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_LO:
            begin
                state_next = S_HI;
            end
            S_HI:
            begin
                state_next = (too_long || too_short) ? S_IDLE : S_HDR;
            end
            S_HDR:
            begin
                if (slot_free && hdr_idx_reg == 2'd2)
                begin
                    state_next = S_BODY;
                end
            end
            S_BODY:
            begin
                if (slot_free && rem_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ptr_cmd  = '0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        out_load = 1'b0;
        out_item = '{out_byte: 8'd0, status: ST_OK, last_byte: 1'b1,
                     fill_level: ptr_stat.fill[7:0]};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.opcode)
                        OP_PUSH:
                        begin
                            out_load = 1'b1;
                            if (ptr_stat.full)
                            begin
                                out_item.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                ptr_cmd.wr_inc = 1'b1;
                                out_item.fill_level = 8'(ptr_stat.fill + 1'b1);
                            end
                        end
                        OP_POP:
                        begin
                            if (ptr_stat.empty)
                            begin
                                out_load        = 1'b1;
                                out_item.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re         = 1'b1;
                                ptr_cmd.rd_inc = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            ptr_cmd.clear       = 1'b1;
                            out_load            = 1'b1;
                            out_item.fill_level = 8'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP:
            begin
                out_load          = 1'b1;
                out_item.out_byte = rd_data;
            end
            S_SCAN_RD:
            begin
                if (ptr_stat.empty)
                begin
                    out_load        = 1'b1;
                    out_item.status = ST_EMPTY;
                end
                else
                begin
                    mem_re         = 1'b1;
                    ptr_cmd.rd_inc = 1'b1;
                end
            end
            S_SCAN_CHK:
            begin
                if (hdr_match)
                begin
                    if (few_left)
                    begin
                        ptr_cmd.drop_all    = 1'b1;
                        out_load            = 1'b1;
                        out_item.status     = ST_SHORT;
                        out_item.fill_level = 8'd0;
                    end
                    else
                    begin
                        mem_re         = 1'b1;
                        ptr_cmd.rd_inc = 1'b1;
                    end
                end
            end
            S_LO:
            begin
                mem_re         = 1'b1;
                ptr_cmd.rd_inc = 1'b1;
            end
            S_HI:
            begin
                if (too_long)
                begin
                    out_load        = 1'b1;
                    out_item.status = ST_LONG;
                end
                else if (too_short)
                begin
                    out_load        = 1'b1;
                    out_item.status = ST_SHORT;
                end
            end
            S_HDR:
            begin
                out_load             = slot_free;
                out_item.last_byte   = 1'b0;
                out_item.fill_level  = fill_hdr[7:0];
                case (hdr_idx_reg)
                    2'd0:    out_item.out_byte = HEADER_BYTE;
                    2'd1:    out_item.out_byte = lo_reg;
                    default: out_item.out_byte = rd_data;
                endcase
                // first body read goes out with the last length beat
                if (slot_free && hdr_idx_reg == 2'd2)
                begin
                    mem_re         = 1'b1;
                    ptr_cmd.rd_inc = 1'b1;
                end
            end
            S_BODY:
            begin
                out_load           = slot_free;
                out_item.out_byte  = rd_data;
                out_item.last_byte = (rem_reg == CNT_W'(1));
                if (slot_free && rem_reg != CNT_W'(1))
                begin
                    mem_re         = 1'b1;
                    ptr_cmd.rd_inc = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            max_len_reg <= MAX_LEN_RST;
            hdr_idx_reg <= 2'd0;
            rem_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (state_reg == S_HI)
            begin
                hdr_idx_reg <= 2'd0;
                rem_reg     <= CNT_W'(len_w + 16'd3);
            end
            else if (state_reg == S_HDR && slot_free)
            begin
                hdr_idx_reg <= hdr_idx_reg + 2'd1;
            end
            else if (state_reg == S_BODY && slot_free)
            begin
                rem_reg <= rem_reg - 1'b1;
            end
        end
    end

    // hi byte stays in the read register through the header beats
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LO)
        begin
            lo_reg <= rd_data;
        end
    end

    brf_ring_ptrs #(
        .DEPTH (DEPTH)
    ) u_ptrs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ptr_cmd),
        .rd_ptr (rd_ptr),
        .wr_ptr (wr_ptr),
        .stat   (ptr_stat)
    );

    brf_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_ptr),
        .wr_data (req.in_byte),
        .re      (mem_re),
        .rd_addr (rd_ptr),
        .rd_data (rd_data)
    );

    brf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_item),
        .rsp_stall (rsp_stall),
        .slot_free (slot_free),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_ring_fifo_with_frame_pop. Byte pushes, pops,
// clears and frame pops go in over the request channel. A scoreboard keeps
// its own copy of the ring and predicts every response beat, field by field.
// Directed cases come first. Random frame traffic follows: well-formed frames,
// broken frames and noise. The run sweeps max_body_len, fills the ring to
// capacity once, and mixes sender gaps with response stalls.
// ----------------------------------------------------------------------------

import brf_pkg::*;

class frame_fifo_scoreboard;

    logic [7:0]  ring [DEPTH_DEF];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    logic [5:0]  max_len;
    brf_rsp_t    beats_due[$];
    int unsigned mismatches;
    int unsigned beats_seen;
    int unsigned frames_good;

    function new();
        rd_ptr      = 0;
        wr_ptr      = 0;
        max_len     = MAX_LEN_RST;
        mismatches  = 0;
        beats_seen  = 0;
        frames_good = 0;
    endfunction

    function int unsigned level();
        return (wr_ptr + DEPTH_DEF - rd_ptr) % DEPTH_DEF;
    endfunction

    function int unsigned body_limit();
        int unsigned cap;
        cap = MAX_FRAME_BYTES_DEF - 6;
        return (max_len > cap) ? cap : max_len;
    endfunction

    function logic [7:0] take_byte();
        logic [7:0] b;
        b      = ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % DEPTH_DEF;
        return b;
    endfunction

    function void expect_beat(logic [7:0] b, logic [2:0] st, logic lst, int unsigned fill);
        brf_rsp_t e;
        e.out_byte   = b;
        e.status     = st;
        e.last_byte  = lst;
        e.fill_level = 8'(fill);
        beats_due.push_back(e);
    endfunction

    function void predict_frame_pop();
        logic        found;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  b;
        int unsigned len;
        int unsigned f0;
        found = 1'b0;
        // bytes ahead of the header are dropped silently
        while (!found && rd_ptr != wr_ptr)
            found = (take_byte() == HEADER_BYTE);
        if (!found)
        begin
            expect_beat(8'd0, ST_EMPTY, 1'b1, level());
            return;
        end
        if (level() < 2)
        begin
            rd_ptr = wr_ptr;
            expect_beat(8'd0, ST_SHORT, 1'b1, 0);
            return;
        end
        f0  = level();
        lo  = take_byte();
        hi  = take_byte();
        len = 32'({hi, lo});
        // length check wins over the body check
        if (len > body_limit())
        begin
            expect_beat(8'd0, ST_LONG, 1'b1, level());
            return;
        end
        if (level() < len + 3)
        begin
            expect_beat(8'd0, ST_SHORT, 1'b1, level());
            return;
        end
        expect_beat(HEADER_BYTE, ST_OK, 1'b0, f0);
        expect_beat(lo, ST_OK, 1'b0, f0 - 1);
        expect_beat(hi, ST_OK, 1'b0, f0 - 2);
        for (int unsigned i = 0; i < len + 3; i++)
        begin
            b = take_byte();
            expect_beat(b, ST_OK, i == len + 2, level());
        end
        frames_good++;
    endfunction

    function void note_item(brf_req_t r);
        logic [7:0] b;
        case (r.opcode)
            OP_PUSH:
            begin
                if (((wr_ptr + 1) % DEPTH_DEF) == rd_ptr)
                    expect_beat(8'd0, ST_FULL, 1'b1, level());
                else
                begin
                    ring[wr_ptr] = r.in_byte;
                    wr_ptr       = (wr_ptr + 1) % DEPTH_DEF;
                    expect_beat(8'd0, ST_OK, 1'b1, level());
                end
            end
            OP_POP:
            begin
                if (rd_ptr == wr_ptr)
                    expect_beat(8'd0, ST_EMPTY, 1'b1, level());
                else
                begin
                    b = take_byte();
                    expect_beat(b, ST_OK, 1'b1, level());
                end
            end
            OP_FRAME:
                predict_frame_pop();
            default:
            begin
                rd_ptr = 0;
                wr_ptr = 0;
                expect_beat(8'd0, ST_OK, 1'b1, 0);
            end
        endcase
    endfunction

    function void check_beat(brf_rsp_t got);
        brf_rsp_t want;
        beats_seen++;
        if (beats_due.size() == 0)
        begin
            $error("unexpected beat: out_byte %0d status %0d last_byte %0d fill_level %0d",
                   got.out_byte, got.status, got.last_byte, got.fill_level);
            mismatches++;
            return;
        end
        want = beats_due.pop_front();
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
            mismatches++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.last_byte !== want.last_byte)
        begin
            $error("last_byte: expected %0d, got %0d", want.last_byte, got.last_byte);
            mismatches++;
        end
        if (got.fill_level !== want.fill_level)
        begin
            $error("fill_level: expected %0d, got %0d", want.fill_level, got.fill_level);
            mismatches++;
        end
    endfunction

endclass

module testbench;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    brf_req_t   req       = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    brf_rsp_t   rsp;
    logic       cfg_we    = 1'b0;
    logic [5:0] cfg_wdata = '0;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned items_sent    = 0;

    frame_fifo_scoreboard sb = new();

    always #5 clk = ~clk;

    byte_ring_fifo_with_frame_pop dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_beat(rsp);

    task automatic send_item(input logic [1:0] op, input logic [7:0] data);
        brf_req_t item;
        item.opcode  = op;
        item.in_byte = data;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_item(item);
        items_sent++;
    endtask

    // drop valid and wait out every pending beat
    task automatic settle();
        req_valid <= 1'b0;
        while (sb.beats_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [5:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.max_len = v;
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == HEADER_BYTE)
            b = b ^ 8'h01;
        return b;
    endfunction

    function automatic int unsigned pick_len();
        int unsigned lim;
        int unsigned r;
        lim = sb.body_limit();
        r   = $urandom_range(0, 9);
        if (r == 0)
            return lim;
        if (r < 3)
            return $urandom_range(0, lim);
        return $urandom_range(0, (lim < 6) ? lim : 6);
    endfunction

    task automatic push_frame(input int unsigned len, input int unsigned body_cnt);
        send_item(OP_PUSH, HEADER_BYTE);
        send_item(OP_PUSH, 8'(len));
        send_item(OP_PUSH, 8'(len >> 8));
        repeat (body_cnt) send_item(OP_PUSH, 8'($urandom_range(0, 255)));
    endtask

    // leftovers go either by a clear or by frame pops that chew through them
    task automatic empty_fifo();
        if (sb.level() > 0)
        begin
            if ($urandom_range(0, 1))
                send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            else
                while (sb.level() > 0)
                    send_item(OP_FRAME, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic good_frame();
        int unsigned len;
        empty_fifo();
        len = pick_len();
        repeat ($urandom_range(0, 2)) send_item(OP_PUSH, junk_byte());
        push_frame(len, len + 3);
        send_item(OP_FRAME, 8'($urandom_range(0, 255)));
    endtask

    task automatic bad_frame();
        int unsigned len;
        empty_fifo();
        case ($urandom_range(0, 3))
            0:
            begin
                if ($urandom_range(0, 1))
                    len = $urandom_range(sb.body_limit() + 1, 255);
                else
                    len = $urandom_range(256, 65535);
                push_frame(len, $urandom_range(0, 4));
            end
            1:
            begin
                len = pick_len();
                push_frame(len, $urandom_range(0, len + 2));
            end
            2:
            begin
                send_item(OP_PUSH, HEADER_BYTE);
                if ($urandom_range(0, 1))
                    send_item(OP_PUSH, 8'($urandom_range(0, 255)));
            end
            default:
                repeat ($urandom_range(1, 4)) send_item(OP_PUSH, junk_byte());
        endcase
        send_item(OP_FRAME, 8'($urandom_range(0, 255)));
    endtask

    task automatic noise();
        int unsigned r;
        repeat ($urandom_range(1, 6))
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(OP_PUSH, ($urandom_range(0, 7) == 0) ? HEADER_BYTE
                                                                : 8'($urandom_range(0, 255)));
            else if (r < 70)
                send_item(OP_POP, 8'($urandom_range(0, 255)));
            else if (r < 90)
                send_item(OP_FRAME, 8'($urandom_range(0, 255)));
            else
                send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
        end
    endtask

    // back-to-back frames until the ring refuses pushes, then drain by frames
    task automatic fill_and_drain();
        int unsigned len;
        while (sb.level() < DEPTH_DEF - 1)
        begin
            len = pick_len();
            push_frame(len, len + 3);
        end
        repeat (2) send_item(OP_PUSH, 8'($urandom_range(0, 255)));
        while (sb.level() > 0)
            send_item(OP_FRAME, 8'($urandom_range(0, 255)));
        send_item(OP_FRAME, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [5:0]  cfg_plan [8];
        int unsigned start;
        int unsigned r;
        cfg_plan = '{6'd0, 6'd63, MAX_LEN_RST, 6'd1, 6'd59, 6'd0, 6'd32, 6'd0};
        cfg_plan[5] = 6'($urandom_range(0, 63));
        cfg_plan[7] = 6'($urandom_range(0, 63));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty ring, byte extremes, skipped byte, each frame outcome
        send_item(OP_POP, 8'hFF);
        send_item(OP_FRAME, 8'h00);
        send_item(OP_PUSH, 8'h00);
        send_item(OP_PUSH, 8'hFF);
        send_item(OP_POP, 8'h00);
        send_item(OP_POP, 8'h00);
        send_item(OP_PUSH, 8'h11);
        send_item(OP_PUSH, HEADER_BYTE);
        send_item(OP_PUSH, 8'h01);
        send_item(OP_FRAME, 8'h00);
        push_frame(0, 3);
        send_item(OP_FRAME, 8'h00);
        push_frame(59, 0);
        send_item(OP_FRAME, 8'h00);
        push_frame(2, 1);
        send_item(OP_FRAME, 8'h00);
        send_item(OP_PUSH, 8'h55);
        send_item(OP_CLEAR, 8'hAA);

        for (int p = 0; p < 8; p++)
        begin
            write_max_len(cfg_plan[p]);
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 78; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            start = items_sent;
            if (p == 2)
                fill_and_drain();
            while (items_sent - start < 8)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    good_frame();
                else if (r < 75)
                    bad_frame();
                else
                    noise();
            end
        end

        req_valid <= 1'b0;
        while (sb.beats_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run: %0d items, %0d response beats, %0d whole frames, %0d mismatches",
                 items_sent, sb.beats_seen, sb.frames_good, sb.mismatches);
        $display("max_body_len swept 0..63 over four gap/stall mixes; ring filled once");
        if (sb.mismatches == 0)
            $display("byte_ring_fifo_with_frame_pop verification clean");
        else
            $display("byte_ring_fifo_with_frame_pop verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("byte_ring_fifo_with_frame_pop verification failed");
        $finish;
    end

endmodule
